[hdl/nmea_rmc_pkg.sv]
// Shared constants and types for the RMC sentence position parser.
// Used by nmea_rmc_parse, nmea_rmc_speed and nmea_rmc_position_parser_unit.
package nmea_rmc_pkg;

   // ASCII codes
   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_A     = 8'h41;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   // Counter limits
   localparam logic [16:0] SEG_MAX_VALUE = 17'd99999;
   localparam logic [6:0]  SEG_MAX_LEN   = 7'd127;
   localparam logic [3:0]  COMMA_MAX     = 4'd15;
   localparam logic [2:0]  DOT_MAX       = 3'd7;
   localparam int          LEAD_DEPTH    = 5;

   // Separator positions that pick up a segment
   localparam logic [3:0] COMMA_STATUS   = 4'd1;
   localparam logic [3:0] COMMA_LAT_FRAC = 4'd3;
   localparam logic [3:0] COMMA_LON_FRAC = 4'd5;
   localparam logic [2:0] DOT_LAT        = 3'd1;
   localparam logic [2:0] DOT_LON        = 3'd2;
   localparam logic [2:0] DOT_SPEED      = 3'd3;
   localparam logic [2:0] DOT_COURSE     = 3'd4;

   localparam logic [6:0]  LAT_MIN_LEN = 7'd4;
   localparam logic [6:0]  LON_MIN_LEN = 7'd5;
   localparam logic [6:0]  FRAC_MIN_LEN = 7'd4;

   // Speed arithmetic: floor(p / 100) = (p * RECIP_100) >> RECIP_SHIFT for p < SPEED_SAT_PROD
   localparam logic [7:0]  SCALE_RESET    = 8'd185;
   localparam logic [24:0] SPEED_SAT_PROD = 25'd6553600;
   localparam logic [23:0] RECIP_100      = 24'd10737419;
   localparam int          RECIP_SHIFT    = 30;
   localparam logic [15:0] SPEED_MAX      = 16'hFFFF;
   localparam logic [15:0] COURSE_MAX     = 16'hFFFF;

   // Result fields other than ground speed
   typedef struct packed {
      logic        fix_valid;
      logic [6:0]  lat_degrees;
      logic [6:0]  lat_minutes;
      logic [16:0] lat_minute_fraction;
      logic [9:0]  lon_degrees;
      logic [6:0]  lon_minutes;
      logic [16:0] lon_minute_fraction;
      logic [15:0] course_degrees;
   } rmc_fix_type;

   // Parser to speed pipeline
   typedef struct packed {
      logic        res_vld;
      logic        spd_upd;
      logic [16:0] spd_val;
      rmc_fix_type fix;
   } rmc_item_type;

   typedef struct packed {
      logic        res_vld;
      logic        spd_upd;
      logic [24:0] prod;
      rmc_fix_type fix;
   } rmc_prod_type;

endpackage

[hdl/nmea_rmc_parse.sv]
// Per-byte sentence parser: separator counts, segment accumulation, kept values.
// Depends on nmea_rmc_pkg.
module nmea_rmc_parse import nmea_rmc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         beat_accept,
   input  logic [7:0]   rx_byte,
   input  logic         end_of_sentence,
   output rmc_item_type item
);

   logic [3:0]  comma_count_ff, comma_count_in;
   logic [2:0]  dot_count_ff, dot_count_in;
   logic [6:0]  seg_len_ff, seg_len_in;
   logic [16:0] seg_value_ff, seg_value_in;
   logic [3:0]  lead_ff [LEAD_DEPTH];
   logic [3:0]  lead_in [LEAD_DEPTH];
   logic        status_pending_ff, status_pending_in;
   rmc_fix_type kept_ff, kept_in;

   logic        is_comma, is_dot, is_digit;
   logic [3:0]  digit;
   logic [20:0] seg_times10;

   always_comb begin
      is_comma    = (rx_byte == CHAR_COMMA);
      is_dot      = (rx_byte == CHAR_DOT);
      is_digit    = (rx_byte >= CHAR_ZERO) && (rx_byte <= CHAR_NINE);
      digit       = is_digit ? 4'(rx_byte - CHAR_ZERO) : 4'd0;
      seg_times10 = {1'b0, seg_value_ff, 3'b000} + {3'b000, seg_value_ff, 1'b0}
                  + 21'(digit);

      comma_count_in    = comma_count_ff;
      dot_count_in      = dot_count_ff;
      seg_len_in        = seg_len_ff;
      seg_value_in      = seg_value_ff;
      lead_in           = lead_ff;
      status_pending_in = 1'b0;
      kept_in           = kept_ff;

      if (status_pending_ff) begin
         kept_in.fix_valid = (rx_byte == CHAR_A);
      end

      if (is_comma) begin
         if (comma_count_ff == COMMA_STATUS) begin
            status_pending_in = 1'b1;
         end else if (comma_count_ff == COMMA_LAT_FRAC) begin
            if (seg_len_ff >= FRAC_MIN_LEN) kept_in.lat_minute_fraction = seg_value_ff;
         end else if (comma_count_ff == COMMA_LON_FRAC) begin
            if (seg_len_ff >= FRAC_MIN_LEN) kept_in.lon_minute_fraction = seg_value_ff;
         end
         if (comma_count_ff != COMMA_MAX) comma_count_in = comma_count_ff + 4'd1;
      end else if (is_dot) begin
         if (dot_count_ff == DOT_LAT) begin
            if (seg_len_ff >= LAT_MIN_LEN) begin
               kept_in.lat_degrees = 7'(lead_ff[0]) * 7'd10 + 7'(lead_ff[1]);
               kept_in.lat_minutes = 7'(lead_ff[2]) * 7'd10 + 7'(lead_ff[3]);
            end
         end else if (dot_count_ff == DOT_LON) begin
            if (seg_len_ff >= LON_MIN_LEN) begin
               kept_in.lon_degrees = 10'(lead_ff[0]) * 10'd100 + 10'(lead_ff[1]) * 10'd10
                                   + 10'(lead_ff[2]);
               kept_in.lon_minutes = 7'(lead_ff[3]) * 7'd10 + 7'(lead_ff[4]);
            end
         end else if (dot_count_ff == DOT_COURSE) begin
            kept_in.course_degrees = (seg_value_ff > 17'(COURSE_MAX)) ? COURSE_MAX
                                                                     : seg_value_ff[15:0];
         end
         if (dot_count_ff != DOT_MAX) dot_count_in = dot_count_ff + 3'd1;
      end else begin
         for (int i = 0; i < LEAD_DEPTH; i++) begin
            if (seg_len_ff == 7'(i)) lead_in[i] = digit;
         end
         if (is_digit) begin
            seg_value_in = (seg_times10 > 21'(SEG_MAX_VALUE)) ? SEG_MAX_VALUE
                                                               : seg_times10[16:0];
         end
         if (seg_len_ff != SEG_MAX_LEN) seg_len_in = seg_len_ff + 7'd1;
      end

      if (is_comma || is_dot || end_of_sentence) begin
         seg_len_in   = '0;
         seg_value_in = '0;
         for (int i = 0; i < LEAD_DEPTH; i++) lead_in[i] = 4'd0;
      end

      if (end_of_sentence) begin
         // status comma as the last byte: nothing follows it
         if (status_pending_in) kept_in.fix_valid = 1'b0;
         comma_count_in    = '0;
         dot_count_in      = '0;
         status_pending_in = 1'b0;
      end

      item.res_vld = end_of_sentence;
      item.spd_upd = is_dot && (dot_count_ff == DOT_SPEED);
      item.spd_val = seg_value_ff;
      item.fix     = kept_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         comma_count_ff    <= '0;
         dot_count_ff      <= '0;
         seg_len_ff        <= '0;
         seg_value_ff      <= '0;
         for (int i = 0; i < LEAD_DEPTH; i++) lead_ff[i] <= 4'd0;
         status_pending_ff <= 1'b0;
         kept_ff           <= '0;
      end else if (beat_accept) begin
         comma_count_ff    <= comma_count_in;
         dot_count_ff      <= dot_count_in;
         seg_len_ff        <= seg_len_in;
         seg_value_ff      <= seg_value_in;
         lead_ff           <= lead_in;
         status_pending_ff <= status_pending_in;
         kept_ff           <= kept_in;
      end
   end

   a_seg_value_bound: assert property (@(posedge clock) disable iff (reset)
      seg_value_ff <= SEG_MAX_VALUE)
      else $error("segment value above saturation limit");

   a_sentence_clear: assert property (@(posedge clock) disable iff (reset)
      beat_accept && end_of_sentence |=> comma_count_ff == '0 && dot_count_ff == '0
                                         && seg_len_ff == '0 && !status_pending_ff)
      else $error("sentence counters not cleared after last beat");

   a_kept_ranges: assert property (@(posedge clock) disable iff (reset)
      kept_ff.lat_degrees <= 7'd99 && kept_ff.lat_minutes <= 7'd99
      && kept_ff.lon_minutes <= 7'd99 && kept_ff.lon_degrees <= 10'd999)
      else $error("kept position value out of range");

endmodule

[hdl/nmea_rmc_speed.sv]
// Speed scaling pipeline (scale multiply, divide by 100) and the result register.
// Depends on nmea_rmc_pkg.
module nmea_rmc_speed import nmea_rmc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         item_load,
   input  rmc_item_type item,
   input  logic [7:0]   speed_scale,
   output logic         advance,
   input  logic         rsp_stall,
   output logic         rsp_valid,
   output rmc_fix_type  rsp_fix,
   output logic [15:0]  rsp_ground_speed
);

   rmc_item_type p1_ff, p1_in;
   rmc_prod_type p2_ff, p2_in;
   logic [15:0]  kept_speed_ff;
   logic         rsp_valid_ff;
   rmc_fix_type  rsp_fix_ff;
   logic [15:0]  rsp_speed_ff;

   logic [46:0]  recip_prod;
   logic [15:0]  quotient;
   logic [15:0]  speed_now;

   // a second result can't enter the output register while the first is stalled
   assign advance = !(rsp_valid_ff && rsp_stall && p2_ff.res_vld);

   always_comb begin
      p1_in         = item;
      p1_in.res_vld = item_load && item.res_vld;
      p1_in.spd_upd = item_load && item.spd_upd;

      p2_in.res_vld = p1_ff.res_vld;
      p2_in.spd_upd = p1_ff.spd_upd;
      p2_in.prod    = 25'(p1_ff.spd_val) * 25'(speed_scale);
      p2_in.fix     = p1_ff.fix;

      recip_prod = 47'(p2_ff.prod[22:0]) * 47'(RECIP_100);
      quotient   = (p2_ff.prod >= SPEED_SAT_PROD) ? SPEED_MAX
                                                  : recip_prod[RECIP_SHIFT +: 16];
      speed_now  = p2_ff.spd_upd ? quotient : kept_speed_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_ff         <= '0;
         p2_ff         <= '0;
         kept_speed_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else if (advance) begin
         p1_ff         <= p1_in;
         p2_ff         <= p2_in;
         kept_speed_ff <= speed_now;
         rsp_valid_ff  <= p2_ff.res_vld || (rsp_valid_ff && rsp_stall);
      end
   end

   always_ff @(posedge clock) begin
      if (advance && p2_ff.res_vld) begin
         rsp_fix_ff   <= p2_ff.fix;
         rsp_speed_ff <= speed_now;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_fix          = rsp_fix_ff;
   assign rsp_ground_speed = rsp_speed_ff;

   a_no_result_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall && p2_ff.res_vld |=> rsp_valid_ff && p2_ff.res_vld)
      else $error("pending result lost while output stalled");

   a_result_follows_p2: assert property (@(posedge clock) disable iff (reset)
      p2_ff.res_vld && advance |=> rsp_valid_ff)
      else $error("result in final stage did not reach output register");

   a_stalled_result_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> rsp_valid_ff && $stable(rsp_fix_ff)
                                    && $stable(rsp_speed_ff))
      else $error("stalled result changed");

endmodule

[hdl/nmea_rmc_position_parser_unit.sv]
// Top level of the RMC sentence position parser: CSR register and channel wiring.
// Depends on nmea_rmc_pkg, nmea_rmc_parse and nmea_rmc_speed.
//
// Usage:
//   req channel: one sentence byte per beat (req_rx_byte), req_end_of_sentence
//   on the last byte. A beat is taken when req_valid is high and req_stall low.
//   rsp channel: one result per sentence, presented on the rsp_ ports while
//   rsp_valid is high, taken when rsp_stall is low.
//   csr channel: csr_speed_scale_hundredths (reset 185 = 1.85) is written when
//   csr_valid and csr_ready are high; csr_ready is always high. Write it only
//   while no sentence is in flight.
// Throughput: one byte per cycle while req_stall is low. Parsing state is updated
//   at the accepting edge; the result then passes the item register, the scale
//   multiply stage and the divide by 100 stage before rsp_valid rises.
// Stall: a waiting result does not block input. req_stall rises only when a
//   second result reaches the last pipeline stage while the output register
//   is still stalled; it then holds the pipeline until the result is taken.
// Reset: clears all counters and kept values to zero, scale to 185, and
//   empties the pipeline. No result is pending after reset.
module nmea_rmc_position_parser_unit import nmea_rmc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   input  logic        req_end_of_sentence,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_fix_valid,
   output logic [6:0]  rsp_lat_degrees,
   output logic [6:0]  rsp_lat_minutes,
   output logic [16:0] rsp_lat_minute_fraction,
   output logic [9:0]  rsp_lon_degrees,
   output logic [6:0]  rsp_lon_minutes,
   output logic [16:0] rsp_lon_minute_fraction,
   output logic [15:0] rsp_ground_speed,
   output logic [15:0] rsp_course_degrees,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_speed_scale_hundredths
);

   logic [7:0]   scale_ff;
   logic         advance;
   logic         beat_accept;
   rmc_item_type item;
   rmc_fix_type  fix;

   assign csr_ready   = 1'b1;
   assign req_stall   = !advance;
   assign beat_accept = req_valid && advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= SCALE_RESET;
      end else if (csr_valid && csr_ready) begin
         scale_ff <= csr_speed_scale_hundredths;
      end
   end

   nmea_rmc_parse u_parse (
      .clock           (clock),
      .reset           (reset),
      .beat_accept     (beat_accept),
      .rx_byte         (req_rx_byte),
      .end_of_sentence (req_end_of_sentence),
      .item            (item)
   );

   nmea_rmc_speed u_speed (
      .clock            (clock),
      .reset            (reset),
      .item_load        (beat_accept),
      .item             (item),
      .speed_scale      (scale_ff),
      .advance          (advance),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_fix          (fix),
      .rsp_ground_speed (rsp_ground_speed)
   );

   assign rsp_fix_valid           = fix.fix_valid;
   assign rsp_lat_degrees         = fix.lat_degrees;
   assign rsp_lat_minutes         = fix.lat_minutes;
   assign rsp_lat_minute_fraction = fix.lat_minute_fraction;
   assign rsp_lon_degrees         = fix.lon_degrees;
   assign rsp_lon_minutes         = fix.lon_minutes;
   assign rsp_lon_minute_fraction = fix.lon_minute_fraction;
   assign rsp_course_degrees      = fix.course_degrees;

endmodule
